// File: design/dt2b_pkg.sv
// ----------------------------------------------------------------------------
// dt2b_pkg: shared types and constants for the decimal text to binary64 parser
// Holds the unit request, state encodings, binary64 constants and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dt2b_pkg;

	// Arithmetic unit operation
	typedef enum logic {
		OP_MUL,
		OP_ADD
	} fpu_op_t;

	// Request from the sequencer to the arithmetic unit
	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	// Arithmetic unit control states
	typedef enum logic [1:0] {
		FS_IDLE,
		FS_MUL,
		FS_NORM
	} fpu_state_t;

	// Parser phases
	typedef enum logic [3:0] {
		PH_START,
		PH_SIGNED,
		PH_I,
		PH_IN,
		PH_INF,
		PH_INT,
		PH_FRAC,
		PH_EXP,
		PH_EXP_SIGN,
		PH_EXP_DIG,
		PH_STOP_NUM,
		PH_STOP_BAD,
		PH_STOP_INF
	} phase_t;

	// Sequencer states
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_INT_MUL,
		SQ_INT_ADD,
		SQ_FRAC_SCALE,
		SQ_FRAC_MUL,
		SQ_FRAC_ADD,
		SQ_EXP,
		SQ_OUT
	} seq_state_t;

	// binary64 constants
	localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] TEN_BITS  = 64'h4024_0000_0000_0000;
	localparam logic [63:0] TENTH_BITS = 64'h3FB9_9999_9999_999A;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_I_LO  = 8'h69;
	localparam logic [7:0] CH_I_UP  = 8'h49;
	localparam logic [7:0] CH_N_LO  = 8'h6E;
	localparam logic [7:0] CH_N_UP  = 8'h4E;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_F_UP  = 8'h46;

endpackage

`default_nettype wire

// File: design/dt2b_fpu.sv
// ----------------------------------------------------------------------------
// dt2b_fpu: shared binary64 multiply / add unit
// Multi-cycle unit for non-negative operands: a 53x17 multiplier step runs four
// times per product, an add is aligned as its operands are loaded, and a one-bit shifter
// normalizes before round-to-nearest-even and packing.
// ----------------------------------------------------------------------------
`default_nettype none

module dt2b_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  dt2b_pkg::fpu_req_t req,
	input  logic [63:0]       opa,
	input  logic [63:0]       opb,
	output logic              done,
	output logic [63:0]       result
);
	import dt2b_pkg::*;

	typedef struct packed {
		logic               inf;
		logic signed [12:0] e;
		logic [52:0]        sig;
	} unp_t;

	localparam logic signed [12:0] EMIN = -13'sd1022;

	function automatic unp_t unpack(input logic [63:0] x);
		unp_t u;
		begin
			u.inf = (x[62:52] == 11'h7FF);
			if (x[62:52] == 11'd0) begin
				u.sig = {1'b0, x[51:0]};
				u.e   = EMIN;
			end else begin
				u.sig = {1'b1, x[51:0]};
				u.e   = $signed({2'b00, x[62:52]}) - 13'sd1023;
			end
			return u;
		end
	endfunction

	fpu_state_t st_q, st_n;

	logic [110:0]       m_q;
	logic signed [12:0] e_q;
	logic               sticky_q;
	logic [120:0]       acc_q;
	logic [52:0]        asig_q;
	logic [67:0]        bsh_q;
	logic [1:0]         cnt_q;
	logic [63:0]        res_q;
	logic               done_q;

	unp_t               ua, ub, ubig, usml;
	logic signed [12:0] ediff;
	logic [110:0]       mbig, msml, msh, mmask;
	logic               stk_add;
	logic [69:0]        pp;
	logic [120:0]       acc_n;

	logic               n_ovf, n_zero, n_shl, n_shr;
	logic [52:0]        rsig, rman;
	logic               rinc;
	logic [53:0]        rsum;
	logic signed [12:0] re, rbias;
	logic [63:0]        rpack;

	// Unpack and align operands for an add
	always_comb begin
		ua = unpack(opa);
		ub = unpack(opb);
		if (ua.e >= ub.e) begin
			ubig = ua;
			usml = ub;
		end else begin
			ubig = ub;
			usml = ua;
		end
		ediff = ubig.e - usml.e;
		mbig  = {1'b0, ubig.sig, 57'd0};
		msml  = {1'b0, usml.sig, 57'd0};
		mmask = '0;
		if (ediff > 13'sd110) begin
			msh     = '0;
			stk_add = |usml.sig;
		end else begin
			msh     = msml >> ediff[6:0];
			mmask   = ~({111{1'b1}} << ediff[6:0]);
			stk_add = |(msml & mmask);
		end
	end

	// Multiplier step: one 17-bit chunk of the second significand per cycle
	assign pp    = asig_q * bsh_q[67:51];
	assign acc_n = {acc_q[103:0], 17'd0} + {51'd0, pp};

	// Normalizer decisions
	assign n_ovf  = m_q[110];
	assign n_zero = (m_q == '0);
	assign n_shl  = !m_q[109] && (e_q > EMIN);
	assign n_shr  = (e_q < EMIN);

	// Round to nearest even and pack
	always_comb begin
		rsig = m_q[109:57];
		rinc = m_q[56] && ((|m_q[55:0]) || sticky_q || rsig[0]);
		rsum = {1'b0, rsig} + {53'd0, rinc};
		if (rsum[53]) begin
			rman = rsum[53:1];
			re   = e_q + 13'sd1;
		end else begin
			rman = rsum[52:0];
			re   = e_q;
		end
		rbias = re + 13'sd1023;
		if (!rman[52]) begin
			rpack = {12'd0, rman[51:0]};
		end else if (rbias >= 13'sd2047) begin
			rpack = INF_BITS;
		end else begin
			rpack = {1'b0, rbias[10:0], rman[51:0]};
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FS_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	// Next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			FS_IDLE: begin
				if (req.start && !(ua.inf || ub.inf)) begin
					st_n = (req.op == OP_MUL) ? FS_MUL : FS_NORM;
				end
			end
			FS_MUL: begin
				if (cnt_q == 2'd3) begin
					st_n = FS_NORM;
				end
			end
			FS_NORM: begin
				if (!n_ovf && (n_zero || (!n_shl && !n_shr))) begin
					st_n = FS_IDLE;
				end
			end
			default: st_n = FS_IDLE;
		endcase
	end

	// Completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((st_q == FS_IDLE) && req.start && (ua.inf || ub.inf)) ||
				((st_q == FS_NORM) && (st_n == FS_IDLE));
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (st_q)
			FS_IDLE: begin
				if (req.start) begin
					if (ua.inf || ub.inf) begin
						res_q <= INF_BITS;
					end else if (req.op == OP_MUL) begin
						asig_q   <= ua.sig;
						bsh_q    <= {15'd0, ub.sig};
						acc_q    <= '0;
						cnt_q    <= 2'd0;
						e_q      <= ua.e + ub.e + 13'sd1;
						sticky_q <= 1'b0;
					end else begin
						m_q      <= mbig + msh;
						e_q      <= ubig.e;
						sticky_q <= stk_add;
					end
				end
			end
			FS_MUL: begin
				acc_q <= acc_n;
				bsh_q <= {bsh_q[50:0], 17'd0};
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					m_q <= {1'b0, acc_n[105:0], 4'd0};
				end
			end
			FS_NORM: begin
				if (n_ovf || (!n_zero && !n_shl && n_shr)) begin
					m_q      <= m_q >> 1;
					sticky_q <= sticky_q | m_q[0];
					e_q      <= e_q + 13'sd1;
				end else if (!n_zero && n_shl) begin
					m_q <= m_q << 1;
					e_q <= e_q - 13'sd1;
				end else begin
					res_q <= rpack;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// File: design/decimal_text_to_binary64.sv
// ----------------------------------------------------------------------------
// decimal_text_to_binary64: character-serial decimal string to binary64 parser
// One character per transaction; a zero byte ends the string and yields one
// result transaction with status, value, value-written flag and stop offset.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | ch
//  output  | out_valid / out_stall| status, value_bits, value_written, end_offset
//
//  A non-digit character other than the terminator does not use the unit. A
//  mantissa digit runs the shared binary64 unit two times (integer) or three
//  times (fraction); exponent digits do not use it. The unit normalizes one bit
//  per shift. A terminator after a number adds one multiply per exponent unit.
//  Reset is asynchronous; the parser returns to the start of a string.
//  in_stall is high while a character is being worked; a pending result waiting
//  on out_stall holds only the next terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_binary64 #(
	parameter int MAX_LEN   = 1024,
	parameter int EXP_LIMIT = 2047
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [63:0] value_bits,
	output logic        value_written,
	output logic [10:0] end_offset
);
	import dt2b_pkg::*;

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int EW = $clog2(EXP_LIMIT + 1);

	function automatic logic [63:0] digit_bits(input logic [3:0] d);
		begin
			case (d)
				4'd1:    return 64'h3FF0_0000_0000_0000;
				4'd2:    return 64'h4000_0000_0000_0000;
				4'd3:    return 64'h4008_0000_0000_0000;
				4'd4:    return 64'h4010_0000_0000_0000;
				4'd5:    return 64'h4014_0000_0000_0000;
				4'd6:    return 64'h4018_0000_0000_0000;
				4'd7:    return 64'h401C_0000_0000_0000;
				4'd8:    return 64'h4020_0000_0000_0000;
				4'd9:    return 64'h4022_0000_0000_0000;
				default: return 64'd0;
			endcase
		end
	endfunction

	seq_state_t seq_q, seq_n;
	phase_t     phase_q, ph_n;

	logic          neg_q, eneg_q, seen_q, pend_q;
	logic [63:0]   accum_q, frac_q, tmp_q;
	logic [EW-1:0] ecnt_q;
	logic [PW-1:0] pos_q, stop_q;
	logic [3:0]    dig_q;

	logic          res_st_q, res_wr_q;
	logic [10:0]   res_off_q;
	logic [63:0]   res_bits_q;

	logic          out_valid_q, out_st_q, out_wr_q;
	logic [63:0]   out_bits_q;
	logic [10:0]   out_off_q;

	logic          accept, term, is_dig, numeric_ok, out_free, exp_fin;
	logic [7:0]    dsub;
	logic [3:0]    dval;
	logic          neg_n, eneg_n, stop_ld, do_int, do_frac, ecnt_ld;
	phase_t        lead_ph;
	logic          lead_int;
	logic [EW+3:0] enext;
	logic [EW-1:0] ecnt_sat;
	logic [PW+10:0] pos_ext, stop_ext;
	logic [63:0]   sign_mask;

	fpu_req_t      fpu_req;
	logic [63:0]   fpu_a, fpu_b, fpu_res;
	logic          fpu_done;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (seq_q != SQ_IDLE);
	assign term     = (ch == CH_NUL);
	assign out_free = !out_valid_q || !out_stall;
	assign dsub     = ch - CH_0;
	assign dval     = dsub[3:0];
	assign pos_ext  = {11'd0, pos_q};
	assign stop_ext = {11'd0, stop_q};
	assign sign_mask = neg_q ? SIGN_BIT : 64'd0;
	assign numeric_ok = (phase_q == PH_INT) || (phase_q == PH_EXP_DIG) ||
		((phase_q == PH_FRAC) && seen_q);
	assign exp_fin  = (seq_q == SQ_EXP) && !pend_q && (ecnt_q == '0);

	// Saturating exponent digit accumulate
	assign enext    = (EW+4)'(ecnt_q) * (EW+4)'(10) + (EW+4)'(dval);
	assign ecnt_sat = (enext > (EW+4)'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : enext[EW-1:0];

	// Decode one character against the current phase
	always_comb begin
		is_dig  = ch inside {[CH_0:CH_9]};
		ph_n    = phase_q;
		neg_n   = neg_q;
		eneg_n  = eneg_q;
		stop_ld = 1'b0;
		do_int  = 1'b0;
		do_frac = 1'b0;
		ecnt_ld = 1'b0;
		lead_int = 1'b0;
		if ((ch == CH_I_LO) || (ch == CH_I_UP)) begin
			lead_ph = PH_I;
		end else if (is_dig) begin
			lead_ph  = PH_INT;
			lead_int = 1'b1;
		end else if (ch == CH_DOT) begin
			lead_ph = PH_FRAC;
		end else begin
			lead_ph = PH_STOP_BAD;
		end
		case (phase_q)
			PH_START: begin
				if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
					neg_n = (ch == CH_MINUS);
					ph_n  = PH_SIGNED;
				end else begin
					ph_n   = lead_ph;
					do_int = lead_int;
				end
			end
			PH_SIGNED: begin
				ph_n   = lead_ph;
				do_int = lead_int;
			end
			PH_I: begin
				ph_n = ((ch == CH_N_LO) || (ch == CH_N_UP)) ? PH_IN : PH_STOP_BAD;
			end
			PH_IN: begin
				ph_n = ((ch == CH_F_LO) || (ch == CH_F_UP)) ? PH_INF : PH_STOP_BAD;
			end
			PH_INF: begin
				ph_n    = PH_STOP_INF;
				stop_ld = 1'b1;
			end
			PH_INT: begin
				if (is_dig) begin
					do_int = 1'b1;
				end else if (ch == CH_DOT) begin
					ph_n = PH_FRAC;
				end else if ((ch == CH_E_LO) || (ch == CH_E_UP)) begin
					ph_n = PH_EXP;
				end else begin
					ph_n    = PH_STOP_NUM;
					stop_ld = 1'b1;
				end
			end
			PH_FRAC: begin
				if (is_dig) begin
					do_frac = 1'b1;
				end else if (!seen_q) begin
					ph_n = PH_STOP_BAD;
				end else if ((ch == CH_E_LO) || (ch == CH_E_UP)) begin
					ph_n = PH_EXP;
				end else begin
					ph_n    = PH_STOP_NUM;
					stop_ld = 1'b1;
				end
			end
			PH_EXP: begin
				if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
					eneg_n = (ch == CH_MINUS);
					ph_n   = PH_EXP_SIGN;
				end else if (is_dig) begin
					ecnt_ld = 1'b1;
					ph_n    = PH_EXP_DIG;
				end else begin
					ph_n = PH_STOP_BAD;
				end
			end
			PH_EXP_SIGN: begin
				if (is_dig) begin
					ecnt_ld = 1'b1;
					ph_n    = PH_EXP_DIG;
				end else begin
					ph_n = PH_STOP_BAD;
				end
			end
			PH_EXP_DIG: begin
				if (is_dig) begin
					ecnt_ld = 1'b1;
				end else begin
					ph_n    = PH_STOP_NUM;
					stop_ld = 1'b1;
				end
			end
			PH_STOP_NUM, PH_STOP_BAD, PH_STOP_INF: begin
			end
			default: ph_n = PH_STOP_BAD;
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
		end else begin
			seq_q <= seq_n;
		end
	end

	// Sequencer next state and arithmetic requests
	always_comb begin
		seq_n         = seq_q;
		fpu_req.start = 1'b0;
		fpu_req.op    = OP_MUL;
		fpu_a         = accum_q;
		fpu_b         = TEN_BITS;
		case (seq_q)
			SQ_IDLE: begin
				if (accept) begin
					if (term) begin
						seq_n = numeric_ok ? SQ_EXP : SQ_OUT;
					end else if (do_int) begin
						seq_n = SQ_INT_MUL;
					end else if (do_frac) begin
						seq_n = SQ_FRAC_SCALE;
					end
				end
			end
			SQ_INT_MUL: begin
				fpu_req.start = !pend_q;
				if (fpu_done) begin
					seq_n = SQ_INT_ADD;
				end
			end
			SQ_INT_ADD: begin
				fpu_req.start = !pend_q;
				fpu_req.op    = OP_ADD;
				fpu_a         = tmp_q;
				fpu_b         = digit_bits(dig_q);
				if (fpu_done) begin
					seq_n = SQ_IDLE;
				end
			end
			SQ_FRAC_SCALE: begin
				fpu_req.start = !pend_q;
				fpu_a         = frac_q;
				fpu_b         = TENTH_BITS;
				if (fpu_done) begin
					seq_n = SQ_FRAC_MUL;
				end
			end
			SQ_FRAC_MUL: begin
				fpu_req.start = !pend_q;
				fpu_a         = frac_q;
				fpu_b         = digit_bits(dig_q);
				if (fpu_done) begin
					seq_n = SQ_FRAC_ADD;
				end
			end
			SQ_FRAC_ADD: begin
				fpu_req.start = !pend_q;
				fpu_req.op    = OP_ADD;
				fpu_b         = tmp_q;
				if (fpu_done) begin
					seq_n = SQ_IDLE;
				end
			end
			SQ_EXP: begin
				fpu_req.start = !pend_q && (ecnt_q != '0);
				fpu_b         = eneg_q ? TENTH_BITS : TEN_BITS;
				if (exp_fin) begin
					seq_n = SQ_OUT;
				end
			end
			SQ_OUT: begin
				if (out_free) begin
					seq_n = SQ_IDLE;
				end
			end
			default: seq_n = SQ_IDLE;
		endcase
	end

	// Track an operation in flight on the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (fpu_done) begin
			pend_q <= 1'b0;
		end else if (fpu_req.start) begin
			pend_q <= 1'b1;
		end
	end

	// Parser state: advance on characters, write back arithmetic, clear at end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			accum_q <= 64'd0;
			frac_q  <= ONE_BITS;
			seen_q  <= 1'b0;
			eneg_q  <= 1'b0;
			ecnt_q  <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
		end else if ((seq_q == SQ_OUT) && out_free) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			accum_q <= 64'd0;
			frac_q  <= ONE_BITS;
			seen_q  <= 1'b0;
			eneg_q  <= 1'b0;
			ecnt_q  <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
		end else if (accept && !term) begin
			phase_q <= ph_n;
			neg_q   <= neg_n;
			eneg_q  <= eneg_n;
			if (do_int || do_frac) begin
				seen_q <= 1'b1;
			end
			if (ecnt_ld) begin
				ecnt_q <= ecnt_sat;
			end
			if (stop_ld) begin
				stop_q <= pos_q;
			end
			if (pos_q < PW'(MAX_LEN)) begin
				pos_q <= pos_q + PW'(1);
			end
		end else if (fpu_done) begin
			case (seq_q)
				SQ_INT_ADD, SQ_FRAC_ADD: accum_q <= fpu_res;
				SQ_FRAC_SCALE:           frac_q  <= fpu_res;
				SQ_EXP: begin
					accum_q <= fpu_res;
					ecnt_q  <= ecnt_q - EW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the digit and the temporary product
	always_ff @(posedge clk) begin
		if (accept && !term) begin
			dig_q <= dval;
		end
		if (fpu_done && ((seq_q == SQ_INT_MUL) || (seq_q == SQ_FRAC_MUL))) begin
			tmp_q <= fpu_res;
		end
	end

	// Prepare the result at the terminator; numeric value after the exponent loop
	always_ff @(posedge clk) begin
		if (accept && term) begin
			res_st_q   <= 1'b1;
			res_wr_q   <= 1'b0;
			res_off_q  <= 11'd0;
			res_bits_q <= 64'd0;
			if (phase_q == PH_INF) begin
				res_st_q   <= 1'b0;
				res_wr_q   <= 1'b1;
				res_off_q  <= pos_ext[10:0];
				res_bits_q <= INF_BITS | sign_mask;
			end else if (phase_q == PH_STOP_INF) begin
				res_wr_q   <= 1'b1;
				res_off_q  <= stop_ext[10:0];
				res_bits_q <= INF_BITS | sign_mask;
			end else if (numeric_ok) begin
				res_st_q  <= 1'b0;
				res_wr_q  <= 1'b1;
				res_off_q <= pos_ext[10:0];
			end else if (phase_q == PH_STOP_NUM) begin
				res_off_q <= stop_ext[10:0];
			end
		end else if (exp_fin) begin
			res_bits_q <= accum_q ^ sign_mask;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((seq_q == SQ_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((seq_q == SQ_OUT) && out_free) begin
			out_st_q   <= res_st_q;
			out_wr_q   <= res_wr_q;
			out_off_q  <= res_off_q;
			out_bits_q <= res_bits_q;
		end
	end

	dt2b_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.opa    (fpu_a),
		.opb    (fpu_b),
		.done   (fpu_done),
		.result (fpu_res)
	);

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign value_bits    = out_bits_q;
	assign value_written = out_wr_q;
	assign end_offset    = out_off_q;

	// The unit only completes an operation the sequencer started
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_done |-> pend_q)
		else $error("arithmetic unit completed with nothing in flight");

	// Exponent count never passes its limit
	a_exp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= EW'(EXP_LIMIT))
		else $error("exponent count above limit");

	// Position never passes the maximum length
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_LEN))
		else $error("position above maximum length");

	// Leaving the result state always presents a result transaction
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((seq_q == SQ_OUT) && out_free) |=> out_valid)
		else $error("result not presented");

endmodule

`default_nettype wire

// File: tb/sv/decimal_text_to_binary64_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_to_binary64_tb: self-checking bench for the text to binary64 parser
// Feeds character strings (directed corner cases, then random numbers, not
// always well-formed, infinities and noise) under random idling on both channels.
// Each terminator is mirrored by a binary64 parser written with native reals, and
// every result transaction is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_binary64_tb;
	import dt2b_pkg::*;

	localparam int MAX_LEN    = 1024;
	localparam int EXP_LIMIT  = 2047;
	localparam int DRAIN_MARK = 256;

	typedef struct {
		logic        status;
		logic [63:0] value_bits;
		logic        value_written;
		logic [10:0] end_offset;
	} parse_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [63:0] value_bits;
	logic        value_written;
	logic [10:0] end_offset;

	decimal_text_to_binary64 #(.MAX_LEN(MAX_LEN), .EXP_LIMIT(EXP_LIMIT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .ch(ch),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_bits(value_bits),
		.value_written(value_written), .end_offset(end_offset)
	);

	// Bench state
	int            char_q[$];
	parse_result_t parse_q[$];
	int            errors;
	int            gap_max;
	int            stall_max;
	int            in_gap;
	int            stall_left;
	bit            draining;
	bit            drain_done;
	bit            in_taken;
	bit            out_taken;

	// Shadow parser state
	phase_t      sh_phase;
	bit          sh_neg;
	real         sh_accum;
	real         sh_scale;
	bit          sh_digit;
	bit          sh_exp_neg;
	int          sh_exp;
	int          sh_pos;
	int          sh_stop;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic clear_shadow();
		sh_phase   = PH_START;
		sh_neg     = 1'b0;
		sh_accum   = 0.0;
		sh_scale   = 1.0;
		sh_digit   = 1'b0;
		sh_exp_neg = 1'b0;
		sh_exp     = 0;
		sh_pos     = 0;
		sh_stop    = 0;
	endtask

	task automatic lead_char(input logic [7:0] c, input bit dig);
		real prod;
		if (c == CH_I_LO || c == CH_I_UP) begin
			sh_phase = PH_I;
		end else if (dig) begin
			prod = sh_accum * 10.0;
			sh_accum = prod + real'(c - CH_0);
			sh_digit = 1'b1;
			sh_phase = PH_INT;
		end else if (c == CH_DOT) begin
			sh_phase = PH_FRAC;
		end else begin
			sh_phase = PH_STOP_BAD;
		end
	endtask

	task automatic add_exp_digit(input int d);
		int n;
		n = sh_exp * 10 + d;
		sh_exp = (n > EXP_LIMIT) ? EXP_LIMIT : n;
	endtask

	// Advance the shadow parser by one character; push a result on a terminator
	task automatic parse_char(input logic [7:0] c);
		bit            dig;
		int            d;
		real           prod;
		real           v;
		parse_result_t r;
		logic [63:0]   inf;
		dig = (c >= CH_0 && c <= CH_9);
		d = dig ? int'(c - CH_0) : 0;
		if (c == CH_NUL) begin
			r.status = 1'b1;
			r.value_bits = '0;
			r.value_written = 1'b0;
			r.end_offset = '0;
			inf = INF_BITS | (sh_neg ? SIGN_BIT : 64'd0);
			if (sh_phase == PH_INF) begin
				r.status = 1'b0; r.value_written = 1'b1;
				r.value_bits = inf; r.end_offset = sh_pos[10:0];
			end else if (sh_phase == PH_STOP_INF) begin
				r.value_written = 1'b1; r.value_bits = inf;
				r.end_offset = sh_stop[10:0];
			end else if (sh_phase == PH_INT || sh_phase == PH_EXP_DIG ||
					(sh_phase == PH_FRAC && sh_digit)) begin
				v = sh_accum;
				for (int k = 0; k < sh_exp; k++)
					v = sh_exp_neg ? v * 0.1 : v * 10.0;
				r.value_bits = $realtobits(v) ^ (sh_neg ? SIGN_BIT : 64'd0);
				r.status = 1'b0; r.value_written = 1'b1;
				r.end_offset = sh_pos[10:0];
			end else if (sh_phase == PH_STOP_NUM) begin
				r.end_offset = sh_stop[10:0];
			end
			parse_q.push_back(r);
			clear_shadow();
			return;
		end
		case (sh_phase)
			PH_START: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					sh_neg = (c == CH_MINUS);
					sh_phase = PH_SIGNED;
				end else lead_char(c, dig);
			end
			PH_SIGNED: lead_char(c, dig);
			PH_I: sh_phase = (c == CH_N_LO || c == CH_N_UP) ? PH_IN : PH_STOP_BAD;
			PH_IN: sh_phase = (c == CH_F_LO || c == CH_F_UP) ? PH_INF : PH_STOP_BAD;
			PH_INF: begin
				sh_phase = PH_STOP_INF;
				sh_stop = sh_pos;
			end
			PH_INT: begin
				if (dig) begin
					prod = sh_accum * 10.0;
					sh_accum = prod + real'(d);
				end else if (c == CH_DOT) sh_phase = PH_FRAC;
				else if (c == CH_E_LO || c == CH_E_UP) sh_phase = PH_EXP;
				else begin
					sh_phase = PH_STOP_NUM;
					sh_stop = sh_pos;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					sh_scale = sh_scale * 0.1;
					prod = sh_scale * real'(d);
					sh_accum = sh_accum + prod;
					sh_digit = 1'b1;
				end else if (!sh_digit) sh_phase = PH_STOP_BAD;
				else if (c == CH_E_LO || c == CH_E_UP) sh_phase = PH_EXP;
				else begin
					sh_phase = PH_STOP_NUM;
					sh_stop = sh_pos;
				end
			end
			PH_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					sh_exp_neg = (c == CH_MINUS);
					sh_phase = PH_EXP_SIGN;
				end else if (dig) begin
					add_exp_digit(d);
					sh_phase = PH_EXP_DIG;
				end else sh_phase = PH_STOP_BAD;
			end
			PH_EXP_SIGN: begin
				if (dig) begin
					add_exp_digit(d);
					sh_phase = PH_EXP_DIG;
				end else sh_phase = PH_STOP_BAD;
			end
			PH_EXP_DIG: begin
				if (dig) add_exp_digit(d);
				else begin
					sh_phase = PH_STOP_NUM;
					sh_stop = sh_pos;
				end
			end
			PH_STOP_NUM, PH_STOP_BAD, PH_STOP_INF: ;
			default: sh_phase = PH_STOP_BAD;
		endcase
		if (sh_pos < MAX_LEN) sh_pos++;
	endtask

	// Record handshakes, predict on accepted characters, check accepted results
	always @(posedge clk) begin
		parse_result_t e;
		in_taken <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (parse_q.size() == 0) begin
				report("result with no string pending");
			end else begin
				e = parse_q.pop_front();
				if (status !== e.status)
					report($sformatf("status %b exp %b", status, e.status));
				if (value_bits !== e.value_bits)
					report($sformatf("value %h exp %h", value_bits, e.value_bits));
				if (value_written !== e.value_written)
					report($sformatf("written %b exp %b", value_written,
						e.value_written));
				if (end_offset !== e.end_offset)
					report($sformatf("offset %0d exp %0d", end_offset, e.end_offset));
			end
		end
		if (arst_n && in_valid && !in_stall)
			parse_char(ch);
	end

	// Drive characters: hold while stalled, otherwise idle or pull the next one
	always @(negedge clk) begin
		logic       nv;
		logic [7:0] nch;
		int         x;
		nv = in_valid;
		nch = ch;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!(in_valid && !in_taken)) begin
			nv = 1'b0;
			if (draining) begin
				if (parse_q.size() == 0) draining = 1'b0;
			end else if (in_gap > 0) begin
				in_gap--;
			end else if (char_q.size() > 0) begin
				x = char_q.pop_front();
				if (x == DRAIN_MARK) begin
					draining = 1'b1;
				end else begin
					nv = 1'b1;
					nch = x[7:0];
					in_gap = $urandom_range(0, gap_max);
				end
			end
		end
		in_valid <= nv;
		ch <= nch;
	end

	// Drive result stalls: a fresh wait count per result
	always @(negedge clk) begin
		if (out_taken) stall_left = $urandom_range(0, stall_max);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
	endtask

	task automatic put_str(input string s);
		put_text(s);
		char_q.push_back(CH_NUL);
	endtask

	task automatic put_digits(input int n);
		repeat (n) char_q.push_back(CH_0 + $urandom_range(0, 9));
	endtask

	// Random number, not always well-formed, with optional garbage tail
	task automatic put_number();
		int ex;
		case ($urandom_range(0, 3))
			0: char_q.push_back(CH_PLUS);
			1: char_q.push_back(CH_MINUS);
			default: ;
		endcase
		put_digits($urandom_range(0, 12));
		if ($urandom_range(0, 1)) begin
			char_q.push_back(CH_DOT);
			put_digits($urandom_range(0, 10));
		end
		if ($urandom_range(0, 2) == 0) begin
			char_q.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
			case ($urandom_range(0, 2))
				0: char_q.push_back(CH_PLUS);
				1: char_q.push_back(CH_MINUS);
				default: ;
			endcase
			ex = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
				: $urandom_range(0, 40);
			if ($urandom_range(0, 9) != 0) put_text($sformatf("%0d", ex));
		end
		if ($urandom_range(0, 5) == 0) begin
			char_q.push_back($urandom_range(1, 255));
			put_digits($urandom_range(0, 2));
		end
		char_q.push_back(CH_NUL);
	endtask

	task automatic put_inf();
		string w;
		w = "inf";
		if ($urandom_range(0, 1)) char_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		for (int i = 0; i < 3; i++)
			char_q.push_back($urandom_range(0, 1) ? w[i] : w[i] - 8'h20);
		if ($urandom_range(0, 2) == 0) put_text("inity");
		char_q.push_back(CH_NUL);
	endtask

	task automatic put_noise();
		repeat ($urandom_range(1, 6)) char_q.push_back($urandom_range(1, 255));
		char_q.push_back(CH_NUL);
	endtask

	// Stimulus and end of run
	initial begin
		errors = 0;
		gap_max = 0;
		stall_max = 0;
		in_gap = 0;
		stall_left = 0;
		draining = 1'b0;
		drain_done = 1'b0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		out_stall = 1'b0;
		clear_shadow();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		put_str("");
		put_str("0");
		put_str("-9876543210.0123");
		put_str("+.5e-3");
		put_str("12E+2");
		put_str("-InF");
		put_str("infinity");
		put_str("+");
		put_str(".");
		put_str("in");
		put_str("x1");
		put_str("1e");
		put_str("1e+");
		put_str("3.7z9");
		put_str("1e99999");
		put_str("7e-99999");
		put_str("5.");
		char_q.push_back(8'hFF); char_q.push_back(CH_NUL);

		// random strings under varying idle pressure
		for (int n = 0; n < 560; ) begin
			int before_n;
			before_n = char_q.size();
			if (!drain_done && n > 250) begin
				char_q.push_back(DRAIN_MARK);
				drain_done = 1'b1;
			end
			if (n % 150 < 40) begin
				gap_max = 0;
				stall_max = 0;
			end else begin
				gap_max = 6;
				stall_max = 6;
			end
			case ($urandom_range(0, 9))
				0: put_inf();
				1, 2: put_noise();
				default: put_number();
			endcase
			n += char_q.size() - before_n;
			wait (char_q.size() < 40);
		end
		gap_max = 6;
		stall_max = 6;

		wait (char_q.size() == 0 && !draining && !in_valid && parse_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
